// ----- rtl/core/pngs_pkg.sv -----
// Shared types, constants and codes for the packed nibble grid stamper.
package pngs_pkg;

    localparam int CELL_W        = 4;
    localparam int COORD_W       = 8;
    localparam int MASK_W        = 16;
    localparam int CHG_W         = 5;
    localparam int EPOCH_W       = 32;
    localparam int SHAPE_SIDE    = 4;
    localparam int SHAPE_CELLS   = SHAPE_SIDE * SHAPE_SIDE;
    localparam int SHAPE_IDX_W   = $clog2(SHAPE_CELLS);
    localparam int SHAPE_OFF_W   = $clog2(SHAPE_SIDE);
    localparam int SCAN_CNT_W    = $clog2(SHAPE_CELLS + 1);
    localparam int DEF_GRID_COLS = 64;
    localparam int DEF_GRID_ROWS = 32;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_STAMP = 2'd2,
        MODE_CLEAR = 2'd3
    } pngs_mode_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CLEAR,
        S_DONE
    } pngs_state_t;

    // One request to the shared cell update unit.
    typedef struct packed {
        logic              apply;
        logic [CELL_W-1:0] old_col;
        logic [CELL_W-1:0] new_col;
        logic              clear_all;
        logic              bump;
    } pngs_upd_cmd_t;

endpackage

// ----- rtl/core/packed_nibble_grid_stamper_unit.sv -----
// Top level of the packed nibble grid stamper: sequencer, address generation and result register.
//
//   Channel | Dir | Payload ports                                   | Handshake
//   s_      | in  | s_mode s_col_x s_row_y s_colour s_shape_mask    | s_valid/s_ready
//   m_      | out | m_cell_colour m_cells_changed m_change_epoch    | m_valid/m_ready
//           |     | m_grid_empty                                    |
//
// A read or a write passes through one memory read, one compare and write-back, and the
// load of the result register; the next item can be accepted once the result is loaded.
// A stamp walks the sixteen mask positions through the one memory port, one position per
// cycle with the read of one position overlapped with the write-back of the previous one;
// the result register is loaded after the last write-back, and the next item is taken after that.
// A clear sweeps the memory one cell per cycle; the result register is loaded after the sweep,
// and the next item is taken once the result is loaded.
// After reset the same sweep runs over all GRID_COLS*GRID_ROWS cells (2048 at the default size)
// with s_ready low; it produces no item.
// s_ready is high whenever the sequencer is idle, even while a finished result still waits
// in the output register for m_ready; a finished item then waits until that result leaves.
module packed_nibble_grid_stamper_unit #(
    parameter int GRID_COLS = pngs_pkg::DEF_GRID_COLS,
    parameter int GRID_ROWS = pngs_pkg::DEF_GRID_ROWS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_mode,
    input  logic signed [pngs_pkg::COORD_W-1:0] s_col_x,
    input  logic signed [pngs_pkg::COORD_W-1:0] s_row_y,
    input  logic [pngs_pkg::CELL_W-1:0]         s_colour,
    input  logic [pngs_pkg::MASK_W-1:0]         s_shape_mask,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pngs_pkg::CELL_W-1:0]         m_cell_colour,
    output logic [pngs_pkg::CHG_W-1:0]          m_cells_changed,
    output logic [pngs_pkg::EPOCH_W-1:0]        m_change_epoch,
    output logic                                m_grid_empty
);
    import pngs_pkg::*;

    localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int COL_W      = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int ROW_W      = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int OCC_W      = $clog2(CELL_COUNT + 1);
    localparam int TGT_W      = COORD_W + 1;

    // Sequencer state and the latched item.
    pngs_state_t              state_reg, state_next;
    pngs_mode_t               mode_reg, mode_next;
    logic signed [COORD_W-1:0] col_x_reg, col_x_next;
    logic signed [COORD_W-1:0] row_y_reg, row_y_next;
    logic [CELL_W-1:0]        colour_reg, colour_next;
    logic [SHAPE_CELLS-1:0]   mask_reg, mask_next;
    logic [SCAN_CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic [SCAN_CNT_W-1:0]    scan_last_reg, scan_last_next;
    logic                     pend_reg, pend_next;
    logic [ADDR_W-1:0]        pend_addr_reg, pend_addr_next;
    logic [CHG_W-1:0]         changed_reg, changed_next;
    logic [CELL_W-1:0]        rd_val_reg, rd_val_next;
    logic [ADDR_W-1:0]        sweep_reg, sweep_next;
    logic                     clr_op_reg, clr_op_next;

    // Result register.
    logic                     m_valid_reg, m_valid_next;
    logic [CELL_W-1:0]        out_colour_reg, out_colour_next;
    logic [CHG_W-1:0]         out_changed_reg, out_changed_next;
    logic [EPOCH_W-1:0]       out_epoch_reg, out_epoch_next;
    logic                     out_empty_reg, out_empty_next;

    // Memory and update unit connections.
    logic                     rd_en, wr_en;
    logic [ADDR_W-1:0]        rd_addr, wr_addr;
    logic [CELL_W-1:0]        wr_data, rd_data;
    pngs_upd_cmd_t            upd_cmd;
    logic                     upd_changed;
    logic [EPOCH_W-1:0]       epoch;
    logic                     occ_zero;

    // Address generation for the mask position that the scan counter points at.
    logic [SHAPE_IDX_W-1:0]   cell_idx;
    logic [SHAPE_OFF_W-1:0]   off_x, off_y;
    logic signed [TGT_W-1:0]  tgt_x, tgt_y;
    logic                     on_grid;
    logic [COL_W-1:0]         col_idx;
    logic [ROW_W-1:0]         row_idx;
    logic [ADDR_W-1:0]        tgt_addr;

    assign cell_idx = scan_idx_reg[SHAPE_IDX_W-1:0];
    assign off_x    = SHAPE_OFF_W'(cell_idx % SHAPE_SIDE);
    assign off_y    = SHAPE_OFF_W'(cell_idx / SHAPE_SIDE);
    assign tgt_x    = TGT_W'(col_x_reg) + TGT_W'(off_x);
    assign tgt_y    = TGT_W'(row_y_reg) + TGT_W'(off_y);
    // The sign bit rules out negative coordinates; the bound compare the far edges.
    assign on_grid  = !tgt_x[TGT_W-1] && !tgt_y[TGT_W-1]
                      && (tgt_x < TGT_W'(GRID_COLS)) && (tgt_y < TGT_W'(GRID_ROWS));
    assign col_idx  = tgt_x[COL_W-1:0];
    assign row_idx  = tgt_y[ROW_W-1:0];
    assign tgt_addr = ADDR_W'(row_idx * GRID_COLS + col_idx);

    pngs_grid_ram #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pngs_update_unit #(
        .OCC_W (OCC_W)
    ) u_upd (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (upd_cmd),
        .cell_changed (upd_changed),
        .epoch        (epoch),
        .occ_zero     (occ_zero)
    );

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        col_x_next       = col_x_reg;
        row_y_next       = row_y_reg;
        colour_next      = colour_reg;
        mask_next        = mask_reg;
        scan_idx_next    = scan_idx_reg;
        scan_last_next   = scan_last_reg;
        pend_next        = pend_reg;
        pend_addr_next   = pend_addr_reg;
        changed_next     = changed_reg;
        rd_val_next      = rd_val_reg;
        sweep_next       = sweep_reg;
        clr_op_next      = clr_op_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        out_colour_next  = out_colour_reg;
        out_changed_next = out_changed_reg;
        out_epoch_next   = out_epoch_reg;
        out_empty_next   = out_empty_reg;
        rd_en            = 1'b0;
        rd_addr          = tgt_addr;
        wr_en            = 1'b0;
        wr_addr          = pend_addr_reg;
        wr_data          = colour_reg;
        upd_cmd          = '0;
        upd_cmd.old_col  = rd_data;
        upd_cmd.new_col  = colour_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    mode_next     = pngs_mode_t'(s_mode);
                    col_x_next    = s_col_x;
                    row_y_next    = s_row_y;
                    colour_next   = s_colour;
                    scan_idx_next = '0;
                    pend_next     = 1'b0;
                    changed_next  = '0;
                    rd_val_next   = '0;
                    if (pngs_mode_t'(s_mode) == MODE_STAMP) begin
                        mask_next      = s_shape_mask;
                        scan_last_next = SCAN_CNT_W'(SHAPE_CELLS);
                    end else begin
                        // A read or a write is a one-position scan at the origin.
                        mask_next      = SHAPE_CELLS'(1);
                        scan_last_next = SCAN_CNT_W'(1);
                    end
                    if (pngs_mode_t'(s_mode) == MODE_CLEAR) begin
                        upd_cmd.clear_all = 1'b1;
                        upd_cmd.bump      = 1'b1;
                        sweep_next        = '0;
                        clr_op_next       = 1'b1;
                        state_next        = S_CLEAR;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Issue the read for the current position.
                if (scan_idx_reg != scan_last_reg) begin
                    rd_en          = mask_reg[cell_idx] && on_grid;
                    pend_next      = rd_en;
                    pend_addr_next = tgt_addr;
                    scan_idx_next  = scan_idx_reg + SCAN_CNT_W'(1);
                end else begin
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                end
                // Settle the position read in the previous cycle.
                if (pend_reg) begin
                    if (mode_reg == MODE_READ) begin
                        rd_val_next = rd_data;
                    end else begin
                        upd_cmd.apply = 1'b1;
                        if (upd_changed) begin
                            wr_en        = 1'b1;
                            changed_next = changed_reg + CHG_W'(1);
                        end
                    end
                end
            end
            S_CLEAR: begin
                wr_en      = 1'b1;
                wr_addr    = sweep_reg;
                wr_data    = '0;
                sweep_next = sweep_reg + ADDR_W'(1);
                if (sweep_reg == ADDR_W'(CELL_COUNT - 1)) begin
                    state_next = clr_op_reg ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    out_colour_next  = rd_val_reg;
                    out_changed_next = changed_reg;
                    out_epoch_next   = epoch;
                    out_empty_next   = occ_zero;
                    state_next       = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            sweep_reg   <= '0;
            clr_op_reg  <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            clr_op_reg  <= clr_op_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg        <= mode_next;
        col_x_reg       <= col_x_next;
        row_y_reg       <= row_y_next;
        colour_reg      <= colour_next;
        mask_reg        <= mask_next;
        scan_idx_reg    <= scan_idx_next;
        scan_last_reg   <= scan_last_next;
        pend_addr_reg   <= pend_addr_next;
        changed_reg     <= changed_next;
        rd_val_reg      <= rd_val_next;
        out_colour_reg  <= out_colour_next;
        out_changed_reg <= out_changed_next;
        out_epoch_reg   <= out_epoch_next;
        out_empty_reg   <= out_empty_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_cell_colour   = out_colour_reg;
    assign m_cells_changed = out_changed_reg;
    assign m_change_epoch  = out_epoch_reg;
    assign m_grid_empty    = out_empty_reg;

endmodule

// ----- rtl/core/pngs_grid_ram.sv -----
// Single write port, single registered read port memory holding the grid cells.
module pngs_grid_ram #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [pngs_pkg::CELL_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [pngs_pkg::CELL_W-1:0] rd_data
);
    import pngs_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/pngs_update_unit.sv -----
// Shared cell update unit: compares old and new colour and keeps the epoch and occupied count.
module pngs_update_unit #(
    parameter int OCC_W = 12
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pngs_pkg::pngs_upd_cmd_t      cmd,
    output logic                         cell_changed,
    output logic [pngs_pkg::EPOCH_W-1:0] epoch,
    output logic                         occ_zero
);
    import pngs_pkg::*;

    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;

    assign cell_changed = cmd.apply && (cmd.old_col != cmd.new_col);

    always_comb begin
        epoch_next = epoch_reg;
        occ_next   = occ_reg;
        if (cmd.clear_all) begin
            occ_next = '0;
        end else if (cell_changed) begin
            if (cmd.old_col == '0) begin
                occ_next = occ_reg + OCC_W'(1);
            end else if (cmd.new_col == '0) begin
                occ_next = occ_reg - OCC_W'(1);
            end
        end
        if (cmd.bump || cell_changed) begin
            epoch_next = epoch_reg + EPOCH_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_reg <= EPOCH_W'(1);
            occ_reg   <= '0;
        end else begin
            epoch_reg <= epoch_next;
            occ_reg   <= occ_next;
        end
    end

    assign epoch    = epoch_reg;
    assign occ_zero = (occ_reg == '0);

endmodule

// ----- rtl/core/pngs_checker.sv -----
// Port-level checker for the packed nibble grid stamper and its bind statement.
module pngs_port_props (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_cell_colour,
    input logic [4:0]  m_cells_changed,
    input logic [31:0] m_change_epoch,
    input logic        m_grid_empty
);

    // Every item keeps the sequencer busy for at least the following cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready stayed high right after an item was accepted");

    // A stamp changes at most sixteen cells.
    a_changed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_cells_changed <= 5'd16)
        else $error("cells_changed above sixteen");

    // A read that found a colored cell cannot report an empty grid.
    a_read_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_cell_colour != 4'd0) |-> !m_grid_empty)
        else $error("nonzero cell read while grid reported empty");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_change_epoch)
            && $stable(m_cells_changed))
        else $error("result changed while stalled");

endmodule

bind packed_nibble_grid_stamper_unit pngs_port_props u_pngs_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_cell_colour   (m_cell_colour),
    .m_cells_changed (m_cells_changed),
    .m_change_epoch  (m_change_epoch),
    .m_grid_empty    (m_grid_empty)
);
